// ===== hdl/stq_pkg.sv =====
// shared constants and types for the sorted timer queue
`default_nettype none
package stq_pkg;
	localparam int DEFAULT_MAX_TIMERS = 16;
	localparam int TIME_W = 40;
	localparam int MIN_W = 24;
	localparam int ID_W = 4;
	localparam logic [MIN_W-1:0] MIN_INTERVAL_RESET = 24'd100000;
	// widest timer index over the parameter range (up to 64 timers)
	localparam int SLOT_W = 6;
	localparam logic KIND_RESTART = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	// command from the sequencer to the rank cells
	typedef struct packed {
		logic              unlink;
		logic              insert;
		logic [SLOT_W-1:0] id;
		logic [SLOT_W:0]   ins_pos;
	} rank_cmd_t;
endpackage
`default_nettype wire

// ===== hdl/stq_rank.sv =====
// per-timer cells holding active flag and queue position, with head search
`default_nettype none
module stq_rank #(
	parameter int MAX_TIMERS = stq_pkg::DEFAULT_MAX_TIMERS
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  stq_pkg::rank_cmd_t                 cmd,
	output logic [MAX_TIMERS-1:0]              active,
	output logic [$clog2(MAX_TIMERS):0]        count,
	output logic [$clog2(MAX_TIMERS)-1:0]      head_id
);
	import stq_pkg::*;
	localparam int IDW = $clog2(MAX_TIMERS);

	logic [MAX_TIMERS-1:0] act_q;
	logic [IDW-1:0]        pos_q [MAX_TIMERS];
	logic [IDW:0]          cnt_q;
	logic [IDW-1:0]        cid;
	logic [IDW-1:0]        ipos;

	assign cid = cmd.id[IDW-1:0];
	assign ipos = cmd.ins_pos[IDW-1:0];
	assign active = act_q;
	assign count = cnt_q;

	// active flags and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
			cnt_q <= '0;
		end else if (cmd.unlink) begin
			act_q[cid] <= 1'b0;
			cnt_q <= cnt_q - 1'b1;
		end else if (cmd.insert) begin
			act_q[cid] <= 1'b1;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// positions shift around the removed or inserted slot
	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_TIMERS; j++) begin
			if (cmd.unlink && act_q[j] && (pos_q[j] > pos_q[cid]))
				pos_q[j] <= pos_q[j] - 1'b1;
			else if (cmd.insert && IDW'(j) == cid)
				pos_q[j] <= ipos;
			else if (cmd.insert && act_q[j] && (pos_q[j] >= ipos))
				pos_q[j] <= pos_q[j] + 1'b1;
		end
	end

	// head is the active timer at position zero
	always_comb begin
		head_id = '0;
		for (int j = 0; j < MAX_TIMERS; j++) begin
			if (act_q[j] && pos_q[j] == '0)
				head_id = IDW'(j);
		end
	end

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		32'($countones(act_q)) == 32'(cnt_q))
		else $error("fill count disagrees with active flags");
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> !act_q[cid])
		else $error("insert of a timer already queued");
	a_unlink_active: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.unlink |-> act_q[cid])
		else $error("unlink of a timer not queued");
endmodule
`default_nettype wire

// ===== hdl/sorted_timer_queue.sv =====
// sorted timer queue: top level with remaining-time memory and sequencer
//
// Requests arrive on the s_ stream: tuser is the kind (restart or remove),
// tdata carries timer id, period and the current hardware countdown. Each
// request gives exactly one beat on the m_ stream with the head timer, the
// delay to program, an empty flag and a status flag.
// A request is worked alone. If the queue is not empty, it reads the head
// value and sweeps the remaining time memory once (one timer a cycle, a two
// stage read-update-write loop); then it unlinks and inserts in the rank
// cells and reads the new head back. The single read port of the remaining
// time memory sets the pace of the sweep. s_tready is high only while the
// sequencer is idle; a finished result sits in the output register, so
// the next request is taken while m_tvalid waits. If the receiver stalls,
// the following request stops before its result until the register drains.
// Reset clears the queue and loads min_interval_us with 100000; the memory
// needs no clearing, since only the values of queued timers are ever used.
`default_nettype none
module sorted_timer_queue #(
	parameter int MAX_TIMERS = stq_pkg::DEFAULT_MAX_TIMERS
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [23:0] cfg_wdata,
	input  wire         s_tvalid,
	output logic        s_tready,
	// timer_id [3:0], period_us [43:4], countdown_us [83:44]
	input  wire  [87:0] s_tdata,
	// kind [0]
	input  wire         s_tuser,
	output logic        m_tvalid,
	input  wire         m_tready,
	// head_timer [3:0], next_delay_us [43:4], queue_empty [44], status [45]
	output logic [47:0] m_tdata
);
	import stq_pkg::*;
	localparam int IDW = $clog2(MAX_TIMERS);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_HRD = 4'd1;
	localparam logic [3:0] ST_HWT = 4'd2;
	localparam logic [3:0] ST_SWEEP = 4'd3;
	localparam logic [3:0] ST_UNLINK = 4'd4;
	localparam logic [3:0] ST_INSERT = 4'd5;
	localparam logic [3:0] ST_ORD = 4'd6;
	localparam logic [3:0] ST_ORW = 4'd7;

	logic [3:0]        state_q;
	logic [MIN_W-1:0]  min_q;
	logic              kind_q;
	logic              idok_q;
	logic [IDW-1:0]    id_q;
	logic [TIME_W-1:0] period_q;
	logic [TIME_W-1:0] cdown_q;
	logic [TIME_W-1:0] elapsed_q;
	logic              status_q;
	logic [IDW:0]      sweep_q;
	logic [IDW:0]      rank_q;
	logic              v_s1, v_s2;
	logic [IDW-1:0]    idx_s1, idx_s2;
	logic [TIME_W-1:0] new_s2;
	logic [TIME_W-1:0] rem_mem [MAX_TIMERS];
	logic [TIME_W-1:0] rd_data_q;
	logic [IDW-1:0]    rd_addr;
	logic              wr_en;
	logic [IDW-1:0]    wr_addr;
	logic [TIME_W-1:0] wr_data;
	logic              out_free;
	logic              res_load;
	logic [TIME_W-1:0] synced;
	logic [TIME_W-1:0] min_ext;
	logic [TIME_W-1:0] delay;
	rank_cmd_t         cmd;
	logic [MAX_TIMERS-1:0] active;
	logic [IDW:0]      count;
	logic [IDW-1:0]    head_id;

	stq_rank #(.MAX_TIMERS(MAX_TIMERS)) u_rank (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.active(active), .count(count), .head_id(head_id)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid || m_tready;
	assign min_ext = TIME_W'(min_q);
	// result beat loaded into the output register this cycle
	assign res_load = out_free &&
		(((state_q == ST_ORD) && (count == '0)) || (state_q == ST_ORW));

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			min_q <= MIN_INTERVAL_RESET;
		else if (cfg_we)
			min_q <= cfg_wdata;
	end

	// remaining time memory with one read port and one write port
	always_ff @(posedge clk) begin
		if (wr_en)
			rem_mem[wr_addr] <= wr_data;
		rd_data_q <= rem_mem[rd_addr];
	end

	always_comb begin
		if (state_q == ST_SWEEP)
			rd_addr = sweep_q[IDW-1:0];
		else
			rd_addr = head_id;
		wr_en = 1'b0;
		wr_addr = idx_s2;
		wr_data = new_s2;
		if (state_q == ST_SWEEP && v_s2 && active[idx_s2]) begin
			wr_en = 1'b1;
		end else if (state_q == ST_INSERT && idok_q && kind_q == KIND_RESTART) begin
			wr_en = 1'b1;
			wr_addr = id_q;
			wr_data = period_q;
		end
	end

	// synced value of one entry, floored at the minimum
	always_comb begin
		if (rd_data_q > elapsed_q && (rd_data_q - elapsed_q) > min_ext)
			synced = rd_data_q - elapsed_q;
		else
			synced = min_ext;
	end

	// rank cell commands
	always_comb begin
		cmd = '0;
		cmd.id = SLOT_W'(id_q);
		cmd.ins_pos = (SLOT_W+1)'(rank_q);
		cmd.unlink = (state_q == ST_UNLINK) && idok_q && active[id_q];
		cmd.insert = (state_q == ST_INSERT) && idok_q && (kind_q == KIND_RESTART);
	end

	assign delay = (rd_data_q == '0) ? min_ext : rd_data_q;

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (res_load)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
			v_s1 <= (state_q == ST_SWEEP) && (sweep_q < (IDW+1)'(MAX_TIMERS));
			v_s2 <= v_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= (count == '0) ? ST_UNLINK : ST_HRD;
				end
				ST_HRD: state_q <= ST_HWT;
				ST_HWT: state_q <= ST_SWEEP;
				ST_SWEEP: begin
					if (sweep_q == (IDW+1)'(MAX_TIMERS) && !v_s1 && !v_s2)
						state_q <= ST_UNLINK;
				end
				ST_UNLINK: state_q <= ST_INSERT;
				ST_INSERT: state_q <= ST_ORD;
				ST_ORD: begin
					if (count == '0) begin
						if (out_free)
							state_q <= ST_IDLE;
					end else begin
						state_q <= ST_ORW;
					end
				end
				ST_ORW: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request fields, sweep pipeline and result
	always_ff @(posedge clk) begin
		idx_s1 <= sweep_q[IDW-1:0];
		idx_s2 <= idx_s1;
		new_s2 <= synced;
		case (state_q)
			ST_IDLE: begin
				kind_q <= s_tuser;
				idok_q <= 32'(s_tdata[3:0]) < MAX_TIMERS;
				id_q <= IDW'(s_tdata[3:0]);
				period_q <= s_tdata[43:4];
				cdown_q <= s_tdata[83:44];
				elapsed_q <= '1;
				sweep_q <= '0;
				rank_q <= '0;
			end
			ST_HWT: elapsed_q <= (rd_data_q > cdown_q) ? rd_data_q - cdown_q : '0;
			ST_SWEEP: begin
				if (sweep_q != (IDW+1)'(MAX_TIMERS))
					sweep_q <= sweep_q + 1'b1;
				if (v_s2 && active[idx_s2] && idx_s2 != id_q && new_s2 <= period_q)
					rank_q <= rank_q + 1'b1;
			end
			ST_UNLINK: status_q <= (kind_q == KIND_REMOVE) && !(idok_q && active[id_q]);
			ST_ORD: begin
				if (count == '0 && out_free)
					m_tdata <= {2'b00, status_q, 1'b1, {TIME_W{1'b0}}, 4'd0};
			end
			ST_ORW: begin
				if (out_free)
					m_tdata <= {2'b00, status_q, 1'b0, delay, 4'(head_id)};
			end
			default: ;
		endcase
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second request taken while busy");
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result dropped while stalled");
	a_sweep_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !wr_en)
		else $error("memory write outside a request");
endmodule
`default_nettype wire
